// File: rtl/core/lfbf_pkg.sv
`timescale 1ns / 1ps

package lfbf_pkg;

  // Ring size; one slot always stays empty, so DEPTH-1 bytes fit
  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] NUL_CODE     = 8'h00;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Item as held in the front queue, already classified
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       message_start;
    logic       is_nul;
    logic       is_nl;
  } lfbf_item_t;

  // Result fields as loaded into the output register
  typedef struct packed {
    logic       full_res;
    logic       dropped;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       line_end;
    logic       empty_res;
  } lfbf_result_t;

  // Ring index advance, wraps at DEPTH
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
    if (p == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

// File: rtl/core/lfbf_in_if.sv
`timescale 1ns / 1ps

interface lfbf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data;
  logic       message_start;

  modport source (output valid, output op, output data, output message_start, input ready);
  modport sink (input valid, input op, input data, input message_start, output ready);
endinterface

// File: rtl/core/lfbf_out_if.sv
`timescale 1ns / 1ps

interface lfbf_out_if;
  logic       valid;
  logic       ready;
  logic       full_res;
  logic       dropped;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       line_end;
  logic       empty_res;

  modport source (
    output valid, output full_res, output dropped, output out_valid,
    output out_byte, output line_end, output empty_res, input ready
  );
  modport sink (
    input valid, input full_res, input dropped, input out_valid,
    input out_byte, input line_end, input empty_res, output ready
  );
endinterface

// File: rtl/core/line_framed_byte_fifo_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                                 Per item
// in_ch     in   op, data[7:0], message_start                            one push or pop
// out_ch    out  full_res, dropped, out_valid, out_byte[7:0], line_end,  one result
//                empty_res
//
// Items pass a two-entry queue, then the executor. A push is done in ST_EXEC;
// a pop of a stored byte also passes ST_POP_RD for the registered memory read.
// Sync reset clears indices, message flags, queue and output register; the
// byte memory is not cleared and needs no clearing pass.
// A stalled out_ch holds the executor; the queue keeps taking up to two items.

module line_framed_byte_fifo_core
  import lfbf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  lfbf_in_if.sink    in_ch,
  lfbf_out_if.source out_ch
);

  logic       item_valid;
  logic       item_take;
  lfbf_item_t item;

  lfbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  lfbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/core/lfbf_front.sv
`timescale 1ns / 1ps

module lfbf_front
  import lfbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lfbf_in_if.sink    in_ch,
  output logic       item_valid,
  output lfbf_item_t item,
  input  logic       item_take
);

  lfbf_item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_q;
  logic       pop_q;
  lfbf_item_t new_item;

  // classify the incoming item
  always_comb begin
    new_item.op            = in_ch.op;
    new_item.data          = in_ch.data;
    new_item.message_start = in_ch.message_start;
    new_item.is_nul        = (in_ch.data == NUL_CODE);
    new_item.is_nl         = (in_ch.data == NEWLINE_CODE);
  end

  assign in_ch.ready = (count != 2'd2);
  assign push_q      = in_ch.valid && in_ch.ready;
  assign pop_q       = item_valid && item_take;
  assign item_valid  = (count != 2'd0);
  assign item        = q[rd_ptr];

  // two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_q) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_q) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_q && !pop_q) begin
        count <= count + 2'd1;
      end else if (pop_q && !push_q) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q[wr_ptr] <= new_item;
    end
  end

endmodule

// File: rtl/core/lfbf_back.sv
`timescale 1ns / 1ps

module lfbf_back
  import lfbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  lfbf_item_t item,
  output logic       item_take,
  lfbf_out_if.source out_ch
);

  localparam logic ST_EXEC   = 1'b0;
  localparam logic ST_POP_RD = 1'b1;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data;
  logic             state;
  logic             state_next;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] read_index;
  logic [IDX_W-1:0] read_index_next;
  logic             prev_nl;
  logic             prev_nl_next;
  logic             stopped;
  logic             stopped_next;
  logic [IDX_W-1:0] wslot;
  logic [IDX_W-1:0] rslot;
  logic [IDX_W-1:0] w_tmp;
  logic             stop_eff;
  logic             prev_eff;
  logic             rd_nl;
  logic             mem_we;
  logic             rd_en;
  logic             load;
  logic             out_free;
  lfbf_result_t     res;
  lfbf_result_t     res_q;
  logic             res_valid;

  assign wslot    = next_slot(write_index);
  assign rslot    = next_slot(read_index);
  assign out_free = !res_valid || out_ch.ready;
  assign rd_nl    = (rd_data == NEWLINE_CODE);

  // execute one item: push in ST_EXEC, pop after the memory read in ST_POP_RD
  always_comb begin
    item_take        = 1'b0;
    load             = 1'b0;
    mem_we           = 1'b0;
    rd_en            = 1'b0;
    res              = '0;
    state_next       = state;
    write_index_next = write_index;
    read_index_next  = read_index;
    prev_nl_next     = prev_nl;
    stopped_next     = stopped;
    stop_eff         = item.message_start ? 1'b0 : stopped;
    prev_eff         = item.message_start ? 1'b1 : prev_nl;
    w_tmp            = write_index;
    case (state)
      ST_EXEC: begin
        if (item_valid && out_free) begin
          item_take = 1'b1;
          if (item.op == OP_PUSH) begin
            load         = 1'b1;
            res.dropped  = 1'b1;
            stopped_next = stop_eff;
            prev_nl_next = prev_eff;
            if (stop_eff) begin
              stopped_next = 1'b1;
            end else if (item.is_nul || (wslot == read_index)) begin
              stopped_next = 1'b1;
            end else begin
              prev_nl_next = item.is_nl;
              if (!(prev_eff && item.is_nl)) begin
                mem_we      = 1'b1;
                res.dropped = 1'b0;
                w_tmp       = wslot;
              end
              stopped_next = (next_slot(w_tmp) == read_index);
            end
            write_index_next = w_tmp;
            res.full_res     = (next_slot(w_tmp) == read_index);
            res.empty_res    = (w_tmp == read_index);
          end else if (read_index == write_index) begin
            // pop from an empty ring
            load          = 1'b1;
            res.full_res  = (wslot == read_index);
            res.empty_res = 1'b1;
          end else begin
            rd_en      = 1'b1;
            state_next = ST_POP_RD;
          end
        end
      end
      ST_POP_RD: begin
        if (out_free) begin
          load            = 1'b1;
          read_index_next = rslot;
          state_next      = ST_EXEC;
          res.out_valid   = 1'b1;
          res.out_byte    = rd_nl ? NUL_CODE : rd_data;
          res.line_end    = rd_nl || (rslot == write_index);
          res.empty_res   = (rslot == write_index);
          res.full_res    = 1'b0;
        end
      end
      default: begin
        state_next = ST_EXEC;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_EXEC;
      write_index <= '0;
      read_index  <= '0;
      prev_nl     <= 1'b1;
      stopped     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      prev_nl     <= prev_nl_next;
      stopped     <= stopped_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  // byte ring storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_index] <= item.data;
    end
    if (rd_en) begin
      rd_data <= mem[read_index];
    end
  end

  assign out_ch.valid     = res_valid;
  assign out_ch.full_res  = res_q.full_res;
  assign out_ch.dropped   = res_q.dropped;
  assign out_ch.out_valid = res_q.out_valid;
  assign out_ch.out_byte  = res_q.out_byte;
  assign out_ch.line_end  = res_q.line_end;
  assign out_ch.empty_res = res_q.empty_res;

endmodule

// File: tb/line_framed_byte_fifo_core_tb.sv
`timescale 1ns / 1ps

module line_framed_byte_fifo_core_tb;
  import lfbf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 10;

  // Directed row: the fixed flag selects the typed-in result over the predictor
  typedef struct packed {
    logic         op;
    logic [7:0]   data;
    logic         message_start;
    logic         fixed;
    lfbf_result_t result;
  } stim_row_t;

  localparam lfbf_result_t NO_RESULT = '0;
  localparam lfbf_result_t EMPTY_IDLE = '{
    full_res: 1'b0, dropped: 1'b0, out_valid: 1'b0, out_byte: 8'h00,
    line_end: 1'b0, empty_res: 1'b1
  };
  localparam lfbf_result_t EMPTY_DROP = '{
    full_res: 1'b0, dropped: 1'b1, out_valid: 1'b0, out_byte: 8'h00,
    line_end: 1'b0, empty_res: 1'b1
  };

  localparam int NUM_DIRECTED = 23;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_POP,  8'h00,        1'b0, 1'b1, EMPTY_IDLE},  // pop while empty after reset
    '{OP_POP,  8'hFF,        1'b1, 1'b1, EMPTY_IDLE},  // message start on a pop is ignored
    '{OP_PUSH, NEWLINE_CODE, 1'b1, 1'b1, EMPTY_DROP},  // newline opening a message
    '{OP_PUSH, NUL_CODE,     1'b1, 1'b1, EMPTY_DROP},  // zero byte ends the message
    '{OP_PUSH, 8'h41,        1'b0, 1'b1, EMPTY_DROP},  // message is stopped
    '{OP_PUSH, 8'hFF,        1'b1, 1'b0, NO_RESULT},
    '{OP_PUSH, NEWLINE_CODE, 1'b0, 1'b0, NO_RESULT},
    '{OP_PUSH, NEWLINE_CODE, 1'b0, 1'b0, NO_RESULT},   // newline after newline
    '{OP_PUSH, 8'h01,        1'b0, 1'b0, NO_RESULT},
    '{OP_PUSH, 8'h80,        1'b0, 1'b0, NO_RESULT},
    '{OP_PUSH, 8'h7F,        1'b0, 1'b0, NO_RESULT},
    '{OP_PUSH, NUL_CODE,     1'b0, 1'b0, NO_RESULT},
    '{OP_PUSH, 8'h55,        1'b0, 1'b0, NO_RESULT},
    '{OP_POP,  8'h00,        1'b0, 1'b0, NO_RESULT},
    '{OP_POP,  8'h00,        1'b0, 1'b0, NO_RESULT},   // newline comes out as zero
    '{OP_POP,  8'h00,        1'b1, 1'b0, NO_RESULT},
    '{OP_POP,  8'h00,        1'b0, 1'b0, NO_RESULT},
    '{OP_POP,  8'h00,        1'b0, 1'b0, NO_RESULT},   // last byte flags line end
    '{OP_POP,  8'h00,        1'b0, 1'b1, EMPTY_IDLE},
    '{OP_PUSH, NEWLINE_CODE, 1'b0, 1'b1, EMPTY_DROP},  // still stopped
    '{OP_PUSH, NEWLINE_CODE, 1'b1, 1'b1, EMPTY_DROP},
    '{OP_PUSH, 8'hAA,        1'b0, 1'b0, NO_RESULT},
    '{OP_POP,  8'h00,        1'b0, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  lfbf_in_if  in_ch ();
  lfbf_out_if out_ch ();

  line_framed_byte_fifo_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow state of the line FIFO
  logic [7:0]       ring_mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr = '0;
  logic [IDX_W-1:0] rd_ptr = '0;
  bit               prev_nl = 1'b1;
  bit               msg_stopped = 1'b0;

  lfbf_result_t expected_results [$];
  int           error_count = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  int           in_max_gap = 0;
  int           out_max_gap = 0;
  bit           hold_request = 1'b0;

  function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] p);
    return IDX_W'((int'(p) + 1) % DEPTH);
  endfunction

  function automatic bit ring_full();
    return ring_advance(wr_ptr) == rd_ptr;
  endfunction

  // Applies one item to the shadow state and returns its result
  function automatic lfbf_result_t predict_fifo_step(input logic op, input logic [7:0] data,
                                                     input logic message_start);
    lfbf_result_t r;
    logic [7:0]   b;
    bit           is_nl;
    r = '0;
    if (op == OP_PUSH) begin
      if (message_start) begin
        msg_stopped = 1'b0;
        prev_nl = 1'b1;
      end
      if (msg_stopped) begin
        r.dropped = 1'b1;
      end else if (data == NUL_CODE || ring_full()) begin
        msg_stopped = 1'b1;
        r.dropped = 1'b1;
      end else begin
        is_nl = (data == NEWLINE_CODE);
        if (prev_nl && is_nl) begin
          r.dropped = 1'b1;
        end else begin
          ring_mem[wr_ptr] = data;
          wr_ptr = ring_advance(wr_ptr);
        end
        prev_nl = is_nl;
        if (ring_full()) msg_stopped = 1'b1;
      end
    end else if (rd_ptr != wr_ptr) begin
      b = ring_mem[rd_ptr];
      rd_ptr = ring_advance(rd_ptr);
      r.out_valid = 1'b1;
      if (b == NEWLINE_CODE) begin
        r.line_end = 1'b1;
      end else begin
        r.out_byte = b;
        r.line_end = (rd_ptr == wr_ptr);
      end
    end
    r.full_res = ring_full();
    r.empty_res = (rd_ptr == wr_ptr);
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Offer one item after a random gap; predict it once accepted
  task automatic offer_item(input logic op, input logic [7:0] data, input logic message_start,
                            input bit fixed, input lfbf_result_t fixed_result);
    int           gap;
    lfbf_result_t predicted;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.data <= data;
    in_ch.message_start <= message_start;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_fifo_step(op, data, message_start);
    expected_results.push_back(fixed ? fixed_result : predicted);
    items_sent++;
  endtask

  function automatic logic [7:0] message_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return NEWLINE_CODE;
    if (pick < 18) return NUL_CODE;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_pops(input int count);
    repeat (count) begin
      offer_item(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
    end
  endtask

  // Well-formed message with pops mixed in, sometimes closed by a zero byte
  task automatic send_message(input int len, input int pop_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < pop_pct) send_pops(1);
      offer_item(OP_PUSH, message_byte(), 1'(i == 0), 1'b0, NO_RESULT);
    end
    if ($urandom_range(0, 1) == 1) offer_item(OP_PUSH, NUL_CODE, 1'b0, 1'b0, NO_RESULT);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int           stall;
    lfbf_result_t act;
    lfbf_result_t exp_r;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = $urandom_range(0, out_max_gap);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      act = '{full_res: out_ch.full_res, dropped: out_ch.dropped,
              out_valid: out_ch.out_valid, out_byte: out_ch.out_byte,
              line_end: out_ch.line_end, empty_res: out_ch.empty_res};
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item pending, expected none actual %p", $time, act);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        compare_field("full_res", 32'(exp_r.full_res), 32'(act.full_res));
        compare_field("dropped", 32'(exp_r.dropped), 32'(act.dropped));
        compare_field("out_valid", 32'(exp_r.out_valid), 32'(act.out_valid));
        compare_field("out_byte", 32'(exp_r.out_byte), 32'(act.out_byte));
        compare_field("line_end", 32'(exp_r.line_end), 32'(act.line_end));
        compare_field("empty_res", 32'(exp_r.empty_res), 32'(act.empty_res));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int phase;
    int pop_pct;
    int pick;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_PUSH;
    in_ch.data <= '0;
    in_ch.message_start <= 1'b0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      in_max_gap = (i < 12) ? 0 : 10;
      out_max_gap = (i < 12) ? 0 : 10;
      offer_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].message_start,
                 DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].result);
    end

    // Random phases: fill-heavy, balanced and drain-heavy
    phase = 0;
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      in_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      out_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      case ($urandom_range(0, 2))
        0: pop_pct = 5;
        1: pop_pct = 40;
        default: pop_pct = 75;
      endcase
      if (phase == 3) begin
        // Long receiver hold-off while the sender streams long messages
        hold_request = 1'b1;
        in_max_gap = 0;
        pop_pct = 0;
      end
      repeat (8) begin
        pick = $urandom_range(0, 99);
        if (phase == 3 || pick < 10) begin
          send_message($urandom_range(30, 45), pop_pct);
        end else if (pick < 65) begin
          send_message($urandom_range(1, 12), pop_pct);
        end else if (pick < 80) begin
          send_pops($urandom_range(1, 20));
        end else begin
          offer_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
        end
      end
      phase++;
    end
    in_ch.valid <= 1'b0;

    // Drain and let the pipeline settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
